/* src/lcd_pkg.sv */
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types, widths and elaboration-time weight table for the layered
// charge deposition core.
// ----------------------------------------------------------------------------
package lcd_pkg;

	localparam int THICK_W   = 32;
	localparam int CUR_W     = 32;
	localparam int DT_W      = 16;
	localparam int ENERGY_W  = 24;
	localparam int ZS_W      = 8;
	localparam int DATA_W    = 48;
	localparam int JDT_W     = CUR_W + DT_W;
	localparam int MUL_W     = 24;
	localparam int PROD_W    = DATA_W + MUL_W;
	localparam int LAYER_W   = 6;
	localparam int STEP_W    = 6;
	localparam int MUL_STEPS = MUL_W;
	localparam int DIV_STEPS = DATA_W;

	localparam logic [DATA_W-1:0]  DATA_MAX     = {DATA_W{1'b1}};
	localparam logic [THICK_W-1:0] THICK_RESET  = 32'd1000000;
	localparam logic               OPC_DEPOSIT  = 1'b0;
	localparam logic               OPC_CLEAR    = 1'b1;

	// operation broadcast from the sequencer to every cell
	typedef enum logic [3:0] {
		OP_IDLE   = 4'd0,
		OP_MLOAD  = 4'd1,
		OP_MSTEP  = 4'd2,
		OP_DLOAD  = 4'd3,
		OP_DSTEP  = 4'd4,
		OP_COMMIT = 4'd5,
		OP_CLEAR  = 4'd6,
		OP_LOAD   = 4'd7,
		OP_SHIFT  = 4'd8
	} lcd_op_t;

	typedef struct packed {
		lcd_op_t op;
		logic    phase;     // 0: charge increment, 1: energy increment
	} lcd_ctl_t;

	typedef struct packed {
		logic [JDT_W-1:0]    jdt;
		logic [ENERGY_W-1:0] energy;
		logic [THICK_W-1:0]  divisor;
	} lcd_bus_t;

	typedef struct packed {
		logic [DATA_W-1:0] charge;
		logic [DATA_W-1:0] energy;
	} lcd_pair_t;

	function automatic logic [DATA_W-1:0] lcd_add_sat(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DATA_W] ? DATA_MAX : s[DATA_W-1:0];
	endfunction

	// Shift-subtract quotient, only used while elaborating the weight table.
	function automatic logic [63:0] lcd_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			quo = {quo[62:0], 1'b0};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-p/q): exp(-p/(8q)) inverted from a 33-term series, squared three times, Q30
	function automatic logic [63:0] lcd_exp_q30(input logic [63:0] p, input logic [63:0] q);
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		term = 64'd1 << 30;
		sum  = term;
		for (int k = 1; k <= 32; k++) begin
			term = lcd_udiv(term * p, 64'd8 * q * 64'(k));
			sum  = sum + term;
		end
		r = lcd_udiv(64'd1 << 60, sum);
		for (int n = 0; n < 3; n++)
			r = (r * r) >> 30;
		return r;
	endfunction

	// Normalized Q0.16 weight of one layer, premultiplied by the layer count
	function automatic logic [MUL_W-1:0] lcd_weight(input int layers, input int idx);
		logic [63:0] e_sel;
		logic [63:0] e;
		logic [63:0] s;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] w;
		e_sel = '0;
		s     = '0;
		for (int j = 0; j < layers; j++) begin
			if (layers < 4) begin
				p = 64'd2 * 64'(j) + 64'd1;
				q = 64'd2;
			end else begin
				p = 64'd4 * 64'(j) + 64'd2;
				q = 64'(layers);
			end
			e = lcd_exp_q30(p, q);
			s = s + e;
			if (j == idx)
				e_sel = e;
		end
		w = (s != 64'd0) ? lcd_udiv((e_sel << 16) + (s >> 1), s) : 64'd0;
		return MUL_W'(w * 64'(layers));
	endfunction

endpackage

/* src/layered_charge_deposition_core.sv */
// ----------------------------------------------------------------------------
// layered_charge_deposition_core
// Per-layer saturating charge and energy accumulators for a slab cut into
// LAYER_COUNT layers, one cell per layer, read out through the cell chain.
// ----------------------------------------------------------------------------
//
//  channel   handshake                    beat
//  -------   ---------------------------  ------------------------------------
//  input     start & !busy                opcode, current_density, time_step,
//                                         mean_energy, charge_state
//  result    result_strobe (no stall)     layer_index, charge_total,
//                                         energy_total, rejected, last_layer
//  config    cfg_we                       cfg_wdata -> slab thickness (nm)
//
//  A deposit runs a charge pass and then an energy pass, each a multiplier
//  load, shift-add multiply, divider load and restoring divide, and then
//  commits, loads and shifts the chain; all cells run both units in parallel,
//  one bit per cycle. A clear goes through clear, load and shift, a rejected
//  item through load and shift. Results leave one beat per cycle, surface
//  layer first; busy stays high until the deepest layer has gone out, so the
//  next item is taken in the cycle after the last beat at the earliest.
//  Reset zeroes both accumulators and loads the thickness with 1000000 nm.
// ----------------------------------------------------------------------------
module layered_charge_deposition_core #(
	parameter int LAYER_COUNT = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lcd_pkg::THICK_W-1:0]       cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic                              opcode,
	input  logic [lcd_pkg::CUR_W-1:0]         current_density,
	input  logic [lcd_pkg::DT_W-1:0]          time_step,
	input  logic [lcd_pkg::ENERGY_W-1:0]      mean_energy,
	input  logic [lcd_pkg::ZS_W-1:0]          charge_state,
	output logic                              result_strobe,
	output logic [lcd_pkg::LAYER_W-1:0]       layer_index,
	output logic [lcd_pkg::DATA_W-1:0]        charge_total,
	output logic [lcd_pkg::DATA_W-1:0]        energy_total,
	output logic                              rejected,
	output logic                              last_layer
);
	import lcd_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MLOAD  = 9'b000000010,
		ST_MUL    = 9'b000000100,
		ST_DLOAD  = 9'b000001000,
		ST_DIV    = 9'b000010000,
		ST_COMMIT = 9'b000100000,
		ST_CLEAR  = 9'b001000000,
		ST_LOAD   = 9'b010000000,
		ST_SHIFT  = 9'b100000000
	} state_t;

	state_t               state_q;
	logic                 phase_q;
	logic [STEP_W-1:0]    step_q;
	logic [LAYER_W-1:0]   layer_q;
	logic                 rejected_q;
	logic [THICK_W-1:0]   thick_q;
	logic [JDT_W-1:0]     jdt_q;
	logic [ENERGY_W-1:0]  energy_q;
	logic [ZS_W-1:0]      zs_q;

	lcd_ctl_t             ctl;
	lcd_bus_t             bus;
	logic [THICK_W-1:0]   thick_eff;
	lcd_pair_t            chain [LAYER_COUNT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thick_q <= THICK_RESET;
		else if (cfg_we)
			thick_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= 1'b0;
			step_q     <= '0;
			layer_q    <= '0;
			rejected_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						phase_q <= 1'b0;
						if (opcode == OPC_CLEAR) begin
							rejected_q <= 1'b0;
							state_q    <= ST_CLEAR;
						end else if (time_step == '0 || charge_state == '0) begin
							rejected_q <= 1'b1;
							state_q    <= ST_LOAD;
						end else begin
							rejected_q <= 1'b0;
							state_q    <= ST_MLOAD;
						end
					end
				end
				ST_MLOAD: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MUL_STEPS - 1))
						state_q <= ST_DLOAD;
				end
				ST_DLOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						// second pass turns the charge increment into energy
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= ST_MLOAD;
						end else begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_COMMIT: state_q <= ST_LOAD;
				ST_CLEAR:  state_q <= ST_LOAD;
				ST_LOAD: begin
					layer_q <= '0;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					layer_q <= layer_q + 1'b1;
					if (layer_q == LAYER_W'(LAYER_COUNT - 1))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operands of the accepted item
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			jdt_q    <= JDT_W'(current_density) * JDT_W'(time_step);
			energy_q <= mean_energy;
			zs_q     <= charge_state;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:   ctl.op = OP_IDLE;
			ST_MLOAD:  ctl.op = OP_MLOAD;
			ST_MUL:    ctl.op = OP_MSTEP;
			ST_DLOAD:  ctl.op = OP_DLOAD;
			ST_DIV:    ctl.op = OP_DSTEP;
			ST_COMMIT: ctl.op = OP_COMMIT;
			ST_CLEAR:  ctl.op = OP_CLEAR;
			ST_LOAD:   ctl.op = OP_LOAD;
			ST_SHIFT:  ctl.op = OP_SHIFT;
			default:   ctl.op = OP_IDLE;
		endcase
		ctl.phase   = phase_q;
		thick_eff   = (thick_q == '0) ? THICK_W'(1) : thick_q;
		bus.jdt     = jdt_q;
		bus.energy  = energy_q;
		bus.divisor = phase_q ? {{(THICK_W-ZS_W){1'b0}}, zs_q} : thick_eff;
	end

	assign chain[LAYER_COUNT] = '0;

	for (genvar i = 0; i < LAYER_COUNT; i++) begin : g_cell
		lcd_cell #(
			.WEIGHT_N (lcd_weight(LAYER_COUNT, i))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.bus       (bus),
			.chain_in  (chain[i+1]),
			.chain_out (chain[i])
		);
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = (state_q == ST_SHIFT);
	assign layer_index   = layer_q;
	assign charge_total  = chain[0].charge;
	assign energy_total  = chain[0].energy;
	assign rejected      = rejected_q;
	assign last_layer    = (layer_q == LAYER_W'(LAYER_COUNT - 1));

endmodule

/* src/lcd_cell.sv */
// ----------------------------------------------------------------------------
// lcd_cell
// One layer: charge and energy accumulators, a shift-add multiplier and a
// restoring divider for the layer increment, and one stage of the readout
// chain toward the surface cell.
// ----------------------------------------------------------------------------
module lcd_cell #(
	parameter logic [lcd_pkg::MUL_W-1:0] WEIGHT_N = 24'd0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lcd_pkg::lcd_ctl_t   ctl,
	input  lcd_pkg::lcd_bus_t   bus,
	input  lcd_pkg::lcd_pair_t  chain_in,
	output lcd_pkg::lcd_pair_t  chain_out
);
	import lcd_pkg::*;

	logic [DATA_W-1:0]  charge_q;
	logic [DATA_W-1:0]  energy_q;
	logic [PROD_W-1:0]  prod_q;
	logic [DATA_W-1:0]  mcand_q;
	logic [THICK_W-1:0] rem_q;
	logic [DATA_W-1:0]  quo_q;
	logic               sat_q;
	logic [DATA_W-1:0]  cinc_q;
	lcd_pair_t          out_q;

	logic [DATA_W:0]    msum;
	logic [THICK_W-1:0] div_hi;
	logic [DATA_W-1:0]  div_lo;
	logic [THICK_W:0]   dshift;
	logic [THICK_W:0]   ddiff;
	logic               dge;
	logic [DATA_W-1:0]  res;

	always_comb begin
		msum = {1'b0, prod_q[PROD_W-1:MUL_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
		// charge: product drops the Q16 weight scale before dividing by thickness
		if (!ctl.phase) begin
			div_hi = {{(THICK_W-8){1'b0}}, prod_q[PROD_W-1:PROD_W-8]};
			div_lo = prod_q[PROD_W-9:PROD_W-8-DATA_W];
		end else begin
			div_hi = {{(THICK_W-MUL_W){1'b0}}, prod_q[PROD_W-1:DATA_W]};
			div_lo = prod_q[DATA_W-1:0];
		end
		dshift = {rem_q, quo_q[DATA_W-1]};
		ddiff  = dshift - {1'b0, bus.divisor};
		dge    = dshift >= {1'b0, bus.divisor};
		res    = sat_q ? DATA_MAX : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q <= '0;
			energy_q <= '0;
		end else begin
			case (ctl.op)
				OP_CLEAR: begin
					charge_q <= '0;
					energy_q <= '0;
				end
				OP_COMMIT: begin
					charge_q <= lcd_add_sat(charge_q, cinc_q);
					energy_q <= lcd_add_sat(energy_q, res);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_MLOAD: begin
				if (!ctl.phase) begin
					mcand_q <= bus.jdt;
					prod_q  <= {{DATA_W{1'b0}}, WEIGHT_N};
				end else begin
					cinc_q  <= res;
					mcand_q <= res;
					prod_q  <= {{DATA_W{1'b0}}, bus.energy};
				end
			end
			OP_MSTEP: prod_q <= {msum, prod_q[MUL_W-1:1]};
			OP_DLOAD: begin
				// quotient would not fit 48 bits: saturate
				sat_q <= div_hi >= bus.divisor;
				rem_q <= div_hi;
				quo_q <= div_lo;
			end
			OP_DSTEP: begin
				rem_q <= dge ? ddiff[THICK_W-1:0] : dshift[THICK_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], dge};
			end
			OP_LOAD:  out_q <= '{charge: charge_q, energy: energy_q};
			OP_SHIFT: out_q <= chain_in;
			default: ;
		endcase
	end

	assign chain_out = out_q;

endmodule

/* src/lcd_checker.sv */
// ----------------------------------------------------------------------------
// lcd_checker
// Port-level checks on the layered charge deposition core: item acceptance
// and the order of the per-layer result beats.
// ----------------------------------------------------------------------------
module lcd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          result_strobe,
	input logic [lcd_pkg::LAYER_W-1:0]   layer_index,
	input logic                          rejected,
	input logic                          last_layer
);
	import lcd_pkg::*;

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result beat outside a busy window");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_layer_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_layer |=>
			result_strobe && layer_index == LAYER_W'($past(layer_index) + 1'b1))
		else $error("result beats not contiguous in layer order");

	a_rejected_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_layer |=> rejected == $past(rejected))
		else $error("rejected flag changed within one item");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_layer |=> !result_strobe && !busy)
		else $error("activity after the deepest layer beat");

endmodule

bind layered_charge_deposition_core lcd_checker u_lcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.layer_index   (layer_index),
	.rejected      (rejected),
	.last_layer    (last_layer)
);
